// ===== sv/output_queued_packet_switch_core_defines.svh =====
// ----------------------------------------------------------------------------
// output queued packet switch core: assertion macros
// shared property forms for the checker on the stream ports
// ----------------------------------------------------------------------------
`ifndef OUTPUT_QUEUED_PACKET_SWITCH_CORE_DEFINES_SVH
`define OUTPUT_QUEUED_PACKET_SWITCH_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define OQS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oqs check failed in the same cycle");

// condition holds in the cycle after the trigger
`define OQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oqs check failed one cycle later");

`endif

// ===== sv/oqs_pkg.sv =====
// ----------------------------------------------------------------------------
// oqs_pkg
// sizes, beat layouts and queue interface types of the packet switch
// ----------------------------------------------------------------------------
package oqs_pkg;

  localparam int NUM_OUTPUTS   = 4;
  localparam int QUEUE_DEPTH   = 8;
  localparam int PAYLOAD_WIDTH = 32;

  // field widths on the stream side
  localparam int DEST_W = 8;
  localparam int PAY_W  = 32;

  localparam int PORT_W  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_W = (PAYLOAD_WIDTH < PAY_W) ? PAYLOAD_WIDTH : PAY_W;

  // input beat: dest_port, payload, dest_busy
  localparam int IN_DEST_LSB = 0;
  localparam int IN_PAY_LSB  = IN_DEST_LSB + DEST_W;
  localparam int IN_BUSY_BIT = IN_PAY_LSB + PAY_W;
  localparam int IN_RAW_W    = IN_BUSY_BIT + 1;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;

  // result beat: enqueued, dropped_full, port_error, fwd_valid, fwd_port, fwd_payload
  localparam int OUT_ENQ_BIT   = 0;
  localparam int OUT_DROP_BIT  = 1;
  localparam int OUT_PERR_BIT  = 2;
  localparam int OUT_FV_BIT    = 3;
  localparam int OUT_PORT_LSB  = 4;
  localparam int OUT_PAY_LSB   = OUT_PORT_LSB + DEST_W;
  localparam int OUT_RAW_W     = OUT_PAY_LSB + PAY_W;
  localparam int OUT_TDATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [PORT_W-1:0]  port_idx_t;
  typedef logic [STORE_W-1:0] store_word_t;

  typedef struct packed {
    logic        full;
    logic        empty;
    store_word_t head_data;
  } q_status_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    store_word_t push_data;
  } q_cmd_t;

endpackage

// ===== sv/oqs_queue_bank.sv =====
// ----------------------------------------------------------------------------
// oqs_queue_bank
// one circular fifo per output port: counts, head pointers and entry store
// ----------------------------------------------------------------------------
module oqs_queue_bank (
  input  logic                clk,
  input  logic                rst,
  input  oqs_pkg::port_idx_t  port,
  input  oqs_pkg::q_cmd_t     cmd,
  output oqs_pkg::q_status_t  status
);
  import oqs_pkg::*;

  localparam logic [HEAD_W:0]   DEPTH_V  = (HEAD_W + 1)'(QUEUE_DEPTH);
  localparam logic [HEAD_W-1:0] HEAD_MAX = HEAD_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  logic [FILL_W-1:0] fill  [NUM_OUTPUTS];
  logic [HEAD_W-1:0] head  [NUM_OUTPUTS];
  store_word_t       store [NUM_OUTPUTS][QUEUE_DEPTH];

  logic [HEAD_W:0]   tail_sum;
  logic [HEAD_W-1:0] tail;
  logic [HEAD_W-1:0] head_inc;

  always_comb begin
    tail_sum = {1'b0, head[port]} + (HEAD_W + 1)'(fill[port]);
    // head and fill are both below depth on a push, so one subtract wraps
    if (tail_sum >= DEPTH_V) begin
      tail = HEAD_W'(tail_sum - DEPTH_V);
    end else begin
      tail = tail_sum[HEAD_W-1:0];
    end
    if (head[port] == HEAD_MAX) begin
      head_inc = '0;
    end else begin
      head_inc = head[port] + HEAD_W'(1);
    end
    status.full      = (fill[port] == FILL_MAX);
    status.empty     = (fill[port] == '0);
    status.head_data = store[port][head[port]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        fill[i] <= '0;
        head[i] <= '0;
      end
    end else begin
      case ({cmd.push, cmd.pop})
        2'b10:   fill[port] <= fill[port] + FILL_W'(1);
        2'b01:   fill[port] <= fill[port] - FILL_W'(1);
        default: fill[port] <= fill[port];
      endcase
      if (cmd.pop) begin
        head[port] <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[port][tail] <= cmd.push_data;
    end
  end

endmodule

// ===== sv/output_queued_packet_switch_core.sv =====
// ----------------------------------------------------------------------------
// output_queued_packet_switch_core
// output queued switch: one fifo per port, append then forward per offer
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  s_axis    in         one packet offer: dest_port, payload, dest_busy
//  m_axis    out        one outcome per offer: flags and forwarded packet
//
//  one offer per cycle while m_axis does not stall; the input register loads
//  at the accepting edge, then the result register, where the outcome shows
//  the queue update and head read of one offer settle in the cycle it moves
//  from the input register into the result register, so the next offer sees
//  the new counts and pointers
//  synchronous reset empties every queue; stored entries are not cleared
//  a stall on m_axis holds the result register and backs up into s_tready
//
module output_queued_packet_switch_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // dest_port[7:0], payload[39:8], dest_busy[40], zero pad
  input  logic [oqs_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // enqueued[0], dropped_full[1], port_error[2], fwd_valid[3],
  // fwd_port[11:4], fwd_payload[43:12], zero pad
  output logic [oqs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import oqs_pkg::*;

  // input register
  logic              in_valid;
  logic [DEST_W-1:0] in_dest;
  store_word_t       in_pay;
  logic              in_busy;

  // moves the held offer into the result register
  logic advance;

  // decision for the offer in the input register
  logic        in_range;
  logic        do_push;
  logic        do_drop;
  logic        do_pop;
  store_word_t fwd_data;

  q_status_t q_status;
  q_cmd_t    q_cmd;

  logic [OUT_TDATA_W-1:0] m_tdata_next;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload bits above the stored width are dropped here
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_dest <= s_tdata[IN_DEST_LSB +: DEST_W];
      in_pay  <= s_tdata[IN_PAY_LSB +: STORE_W];
      in_busy <= s_tdata[IN_BUSY_BIT];
    end
  end

  always_comb begin
    in_range = (in_dest < DEST_W'(NUM_OUTPUTS));
    do_push  = in_range && !q_status.full;
    do_drop  = in_range && q_status.full;
    // the append comes first, so an empty queue with a fresh offer can pop
    do_pop   = in_range && !in_busy && (!q_status.empty || do_push);
    // empty queue: the head is the offer that is being appended now
    if (q_status.empty) begin
      fwd_data = in_pay;
    end else begin
      fwd_data = q_status.head_data;
    end
  end

  // state only moves when the outcome is actually registered
  always_comb begin
    q_cmd.push      = do_push && in_valid && advance;
    q_cmd.pop       = do_pop && in_valid && advance;
    q_cmd.push_data = in_pay;
  end

  oqs_queue_bank u_bank (
    .clk    (clk),
    .rst    (rst),
    .port   (in_dest[PORT_W-1:0]),
    .cmd    (q_cmd),
    .status (q_status)
  );

  always_comb begin
    m_tdata_next                        = '0;
    m_tdata_next[OUT_ENQ_BIT]           = do_push;
    m_tdata_next[OUT_DROP_BIT]          = do_drop;
    m_tdata_next[OUT_PERR_BIT]          = !in_range;
    m_tdata_next[OUT_FV_BIT]            = do_pop;
    if (do_pop) begin
      m_tdata_next[OUT_PORT_LSB +: DEST_W] = in_dest;
      m_tdata_next[OUT_PAY_LSB +: PAY_W]   = PAY_W'(fwd_data);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

// ===== sv/oqs_checker.sv =====
// ----------------------------------------------------------------------------
// oqs_checker
// port level checks on the result stream of the packet switch
// ----------------------------------------------------------------------------
`include "output_queued_packet_switch_core_defines.svh"

module oqs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [oqs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import oqs_pkg::*;

  logic enq;
  logic drop;
  logic perr;
  logic fv;

  assign enq  = m_tdata[OUT_ENQ_BIT];
  assign drop = m_tdata[OUT_DROP_BIT];
  assign perr = m_tdata[OUT_PERR_BIT];
  assign fv   = m_tdata[OUT_FV_BIT];

  // a stalled result stays put
  `OQS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // every offer ends in exactly one of appended, dropped or rejected
  `OQS_ASSERT_NOW(a_one_outcome, clk, rst, m_tvalid, $onehot({enq, drop, perr}))

  // a rejected port never forwards
  `OQS_ASSERT_NOW(a_perr_no_fwd, clk, rst, m_tvalid && perr, !fv)

  // no forward means zero port and payload
  `OQS_ASSERT_NOW(a_idle_fwd_zero, clk, rst, m_tvalid && !fv,
    m_tdata[OUT_PORT_LSB +: DEST_W] == '0 && m_tdata[OUT_PAY_LSB +: PAY_W] == '0)

endmodule

bind output_queued_packet_switch_core oqs_checker u_oqs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
